// ===== hdl/ttm_pkg.sv =====
// Package: types, constants and state codes of the timer multiplexer.
package ttm_pkg;

	localparam int unsigned SLOTS_DEFAULT = 16;
	localparam logic [15:0] CAP_INTERVAL = 16'hfff0;

	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_RESTART = 2'd1,
		MODE_STOP    = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_FIND_CHK,
		S_LAST_RD,
		S_MOVE,
		S_AGE_RD,
		S_AGE_DO,
		S_FIRE,
		S_APPEND,
		S_RELOAD_RD,
		S_RELOAD,
		S_MIN_RD,
		S_MIN_DO,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  timer_id;
		logic [31:0] period;
		logic [1:0]  timer_kind;
		logic [15:0] elapsed;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  fired_id;
		logic        deferred_dispatch;
		logic        reloaded;
		logic [1:0]  status;
		logic [15:0] next_period;
		logic        timer_enabled;
		logic [31:0] local_time;
		logic        last;
	} res_t;

endpackage

// ===== hdl/ttm_if.sv =====
// Interfaces: valid/ready channels for commands and results.
interface ttm_cmd_if;
	logic valid;
	logic ready;
	ttm_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ttm_res_if;
	logic valid;
	logic ready;
	ttm_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tickless_timer_multiplexer.sv =====
// Top level: timer table with a sequencer that ages, removes and searches entries one at a time.
//
//  channel | direction | payload
//  cmd     | in        | mode, timer_id, period, timer_kind, elapsed
//  res     | out       | kind, fired_id, deferred_dispatch, reloaded, status,
//          |           | next_period, timer_enabled, local_time, last
//
// A command is taken in idle; for restart and stop the id search then visits the
// entries in order. Ageing visits every entry but the restart target, a fired
// one-shot has the last entry moved over it, and the command ends with append,
// restart reload, minimum search and a status result. Fire and status wait on output.
// Reset clears the entry count, interval, local time and enable flag; the table
// holds no reset. Output stalls hold the sequencer at the result in flight.
module tickless_timer_multiplexer #(
	parameter int unsigned SLOTS = ttm_pkg::SLOTS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	ttm_cmd_if.sink   cmd,
	ttm_res_if.source res
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	// Table memory: one write and one registered read port
	logic [5:0]  mem_id   [SLOTS];
	logic [31:0] mem_rem  [SLOTS];
	logic [31:0] mem_per  [SLOTS];
	logic [1:0]  mem_kind [SLOTS];

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [5:0]    wid;
	logic [31:0]   wrem, wper;
	logic [1:0]    wkind;
	logic [5:0]    rd_id_q;
	logic [31:0]   rd_rem_q, rd_per_q;
	logic [1:0]    rd_kind_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_id[waddr]   <= wid;
			mem_rem[waddr]  <= wrem;
			mem_per[waddr]  <= wper;
			mem_kind[waddr] <= wkind;
		end
		rd_id_q   <= mem_id[raddr];
		rd_rem_q  <= mem_rem[raddr];
		rd_per_q  <= mem_per[raddr];
		rd_kind_q <= mem_kind[raddr];
	end

	ttm_pkg::state_t state_q, state_d;
	ttm_pkg::cmd_t   cmd_q;
	logic [CW-1:0]   count_q, count_d;
	logic [15:0]     interval_q, interval_d;
	logic [31:0]     time_q, time_d;
	logic            on_q, on_d;
	logic [CW-1:0]   i_q, i_d;
	logic [CW-1:0]   skip_q, skip_d;
	logic            has_skip_q, has_skip_d;
	logic            stop_move_q, stop_move_d;
	logic [15:0]     age_q, age_d;
	logic [15:0]     min_q, min_d;
	logic [1:0]      st_q, st_d;
	logic [CW-1:0]   lastidx;
	logic            rem_le;
	logic [15:0]     min_next;

	assign lastidx = count_q - CW'(1);
	assign rem_le = rd_rem_q <= {16'd0, age_q};
	assign min_next = (rd_rem_q < {16'd0, min_q}) ? rd_rem_q[15:0] : min_q;

	// Next state and datapath updates
	always_comb begin
		state_d = state_q;
		count_d = count_q; interval_d = interval_q; time_d = time_q; on_d = on_q;
		i_d = i_q; skip_d = skip_q; has_skip_d = has_skip_q;
		stop_move_d = stop_move_q;
		age_d = age_q; min_d = min_q; st_d = st_q;
		case (state_q)
			ttm_pkg::S_IDLE: begin
				if (cmd.valid) begin
					i_d = '0; has_skip_d = 1'b0; stop_move_d = 1'b0;
					st_d = ttm_pkg::ST_OK;
					case (cmd.data.mode)
						ttm_pkg::MODE_START: begin
							if (32'(count_q) >= 32'(SLOTS)) begin
								st_d = ttm_pkg::ST_FULL;
								state_d = ttm_pkg::S_STATUS;
							end else begin
								interval_d = cmd.data.elapsed;
								age_d = cmd.data.elapsed;
								state_d = ttm_pkg::S_AGE_RD;
							end
						end
						ttm_pkg::MODE_TICK: begin
							age_d = interval_q;
							state_d = ttm_pkg::S_AGE_RD;
						end
						default: state_d = ttm_pkg::S_FIND;
					endcase
				end
			end
			ttm_pkg::S_FIND: begin
				if (i_q >= count_q) begin
					st_d = ttm_pkg::ST_NOT_FOUND;
					state_d = ttm_pkg::S_STATUS;
				end else state_d = ttm_pkg::S_FIND_CHK;
			end
			ttm_pkg::S_FIND_CHK: begin
				if (rd_id_q == cmd_q.timer_id) begin
					interval_d = cmd_q.elapsed;
					age_d = cmd_q.elapsed;
					if (cmd_q.mode == ttm_pkg::MODE_STOP) begin
						// Drop the target, move the last entry over it unless it is the last
						count_d = lastidx;
						if (i_q < lastidx) begin
							stop_move_d = 1'b1;
							state_d = ttm_pkg::S_LAST_RD;
						end else begin
							i_d = '0;
							state_d = ttm_pkg::S_AGE_RD;
						end
					end else begin
						skip_d = i_q; has_skip_d = 1'b1;
						i_d = '0;
						state_d = ttm_pkg::S_AGE_RD;
					end
				end else begin
					i_d = i_q + CW'(1);
					state_d = ttm_pkg::S_FIND;
				end
			end
			ttm_pkg::S_LAST_RD: state_d = ttm_pkg::S_MOVE;
			ttm_pkg::S_MOVE: begin
				// Stop ages from the first entry; ageing revisits the refilled slot
				if (stop_move_q) begin
					i_d = '0;
					stop_move_d = 1'b0;
				end
				state_d = ttm_pkg::S_AGE_RD;
			end
			ttm_pkg::S_AGE_RD: begin
				if (i_q >= count_q) begin
					time_d = time_q + {16'd0, age_q};
					case (cmd_q.mode)
						ttm_pkg::MODE_START: state_d = ttm_pkg::S_APPEND;
						ttm_pkg::MODE_RESTART: state_d = ttm_pkg::S_RELOAD_RD;
						default: begin
							i_d = '0;
							state_d = ttm_pkg::S_MIN_RD;
						end
					endcase
				end else if (has_skip_q && i_q == skip_q) begin
					i_d = i_q + CW'(1);
				end else state_d = ttm_pkg::S_AGE_DO;
			end
			ttm_pkg::S_AGE_DO: begin
				if (rem_le) state_d = ttm_pkg::S_FIRE;
				else begin
					i_d = i_q + CW'(1);
					state_d = ttm_pkg::S_AGE_RD;
				end
			end
			ttm_pkg::S_FIRE: begin
				if (res.ready) begin
					if (rd_kind_q[0]) begin
						i_d = i_q + CW'(1);
						state_d = ttm_pkg::S_AGE_RD;
					end else begin
						count_d = lastidx;
						if (has_skip_q && skip_q == lastidx && i_q < lastidx)
							skip_d = i_q;
						if (i_q < lastidx) state_d = ttm_pkg::S_LAST_RD;
						else state_d = ttm_pkg::S_AGE_RD;
					end
				end
			end
			ttm_pkg::S_APPEND: begin
				count_d = count_q + CW'(1);
				on_d = 1'b1;
				i_d = '0;
				state_d = ttm_pkg::S_MIN_RD;
			end
			ttm_pkg::S_RELOAD_RD: state_d = ttm_pkg::S_RELOAD;
			ttm_pkg::S_RELOAD: begin
				i_d = '0;
				state_d = ttm_pkg::S_MIN_RD;
			end
			ttm_pkg::S_MIN_RD: begin
				min_d = ttm_pkg::CAP_INTERVAL;
				if (count_q == '0) begin
					on_d = 1'b0;
					state_d = ttm_pkg::S_STATUS;
				end else state_d = ttm_pkg::S_MIN_DO;
			end
			ttm_pkg::S_MIN_DO: begin
				if (i_q + CW'(1) >= count_q) begin
					interval_d = min_next;
					state_d = ttm_pkg::S_STATUS;
				end else begin
					min_d = min_next;
					i_d = i_q + CW'(1);
				end
			end
			ttm_pkg::S_STATUS: begin
				if (res.ready) state_d = ttm_pkg::S_IDLE;
			end
			default: state_d = ttm_pkg::S_IDLE;
		endcase
	end

	// Table port control
	always_comb begin
		we = 1'b0;
		waddr = i_q[IW-1:0];
		raddr = i_q[IW-1:0];
		wid = rd_id_q; wrem = rd_rem_q; wper = rd_per_q; wkind = rd_kind_q;
		case (state_q)
			ttm_pkg::S_AGE_DO: begin
				if (!rem_le) begin
					we = 1'b1;
					wrem = rd_rem_q - {16'd0, age_q};
				end
			end
			ttm_pkg::S_FIRE: begin
				if (res.ready && rd_kind_q[0]) begin
					we = 1'b1;
					wrem = rd_per_q;
				end
			end
			ttm_pkg::S_LAST_RD: raddr = count_q[IW-1:0];
			ttm_pkg::S_MOVE: we = 1'b1;
			ttm_pkg::S_APPEND: begin
				we = 1'b1;
				waddr = count_q[IW-1:0];
				wid = cmd_q.timer_id; wrem = cmd_q.period;
				wper = cmd_q.period; wkind = cmd_q.timer_kind;
			end
			ttm_pkg::S_RELOAD_RD: raddr = skip_q[IW-1:0];
			ttm_pkg::S_RELOAD: begin
				we = 1'b1;
				waddr = skip_q[IW-1:0];
				wrem = rd_per_q;
			end
			ttm_pkg::S_MIN_DO: begin
				if (i_q + CW'(1) < count_q) raddr = IW'(i_q + CW'(1));
			end
			default: ;
		endcase
	end

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttm_pkg::S_IDLE;
			count_q <= '0; interval_q <= '0; time_q <= '0; on_q <= 1'b0;
			i_q <= '0; skip_q <= '0; has_skip_q <= 1'b0; stop_move_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d; interval_q <= interval_d; time_q <= time_d;
			on_q <= on_d; i_q <= i_d; skip_q <= skip_d; has_skip_q <= has_skip_d;
			stop_move_q <= stop_move_d;
		end
	end

	// Hold the command and the working values of the sequencer
	always_ff @(posedge clk) begin
		age_q <= age_d; min_q <= min_d; st_q <= st_d;
		if (state_q == ttm_pkg::S_IDLE && cmd.valid) cmd_q <= cmd.data;
	end

	// Result and handshake outputs
	always_comb begin
		cmd.ready = (state_q == ttm_pkg::S_IDLE);
		res.valid = (state_q == ttm_pkg::S_FIRE) || (state_q == ttm_pkg::S_STATUS);
		res.data = '0;
		if (state_q == ttm_pkg::S_FIRE) begin
			res.data.fired_id = rd_id_q;
			res.data.deferred_dispatch = rd_kind_q[1];
			res.data.reloaded = rd_kind_q[0];
		end else begin
			res.data.kind = 1'b1;
			res.data.last = 1'b1;
			res.data.status = st_q;
			res.data.timer_enabled = on_q;
			res.data.next_period = on_q ? interval_q : 16'd0;
			res.data.local_time = time_q;
		end
	end

endmodule

// ===== hdl/ttm_checker.sv =====
// Checker: port-level properties of the timer multiplexer, bound to the top level.
module ttm_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input ttm_pkg::res_t res_data
);

	// A status result always closes the command
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.kind == res_data.last)) else $error("last mismatch");

	// No command is taken while a result is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd_ready) else $error("overlap");

	// Disabled countdown reports zero interval
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.kind && !res_data.timer_enabled) |->
		(res_data.next_period == 16'd0)) else $error("next_period");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
		else $error("hold");

endmodule

bind tickless_timer_multiplexer ttm_checker u_ttm_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
